[rtl/rau_pkg.sv]
// Shared types, command codes and sequencer states for the rational arithmetic unit.
package rau_pkg;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_REM = 3'd4,
      CMD_CMP = 3'd5
   } cmd_type;

   localparam logic [1:0] ORD_LT = 2'd0;
   localparam logic [1:0] ORD_EQ = 2'd1;
   localparam logic [1:0] ORD_GT = 2'd2;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic [1:0]         order;
      logic               error;
   } rsp_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic        is_signed;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
      logic [31:0] rem;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_NORM_START,   // normalize n_ff/d_ff
      ST_GCD_DIV,
      ST_GCD_WAIT,
      ST_NDIV,
      ST_NDIV_WAIT,
      ST_DDIV,
      ST_DDIV_WAIT,
      ST_NORM_DONE,
      ST_DISPATCH,
      ST_ADD_PROD,
      ST_ADD_L,
      ST_ADD_L_WAIT,
      ST_ADD_LS,
      ST_ADD_LS_WAIT,
      ST_ADD_RS,
      ST_ADD_RS_WAIT,
      ST_ADD_M1,
      ST_ADD_M2,
      ST_MUL,
      ST_REM,
      ST_REM_WAIT,
      ST_CMP1,
      ST_CMP2,
      ST_CMP3,
      ST_DONE
   } state_type;

   // which normalization is running
   typedef enum logic [2:0] {
      NS_A,
      NS_B,
      NS_RECIP,
      NS_RESULT
   } nsel_type;

endpackage

[rtl/rau_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle, truncating signed or unsigned.
module rau_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::div_req_type div_req,
   output rau_pkg::div_rsp_type div_rsp
);
   import rau_pkg::*;

   logic [31:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        qneg_ff, qneg_in;
   logic        rneg_ff, rneg_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] dd_mag, dv_mag;
   logic        dd_neg, dv_neg;

   always_comb begin
      dd_neg = div_req.is_signed & div_req.dividend[31];
      dv_neg = div_req.is_signed & div_req.divisor[31];
      dd_mag = dd_neg ? (32'd0 - div_req.dividend) : div_req.dividend;
      dv_mag = dv_neg ? (32'd0 - div_req.divisor) : div_req.divisor;
      trial  = {r_ff[31:0], q_ff[31]} - {1'b0, dvs_ff};
      q_in = q_ff; r_in = r_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; qneg_in = qneg_ff; rneg_in = rneg_ff; done_in = 1'b0;
      if (div_req.start) begin
         q_in = dd_mag; r_in = '0; dvs_in = dv_mag; cnt_in = 6'd32;
         busy_in = 1'b1; qneg_in = dd_neg ^ dv_neg; rneg_in = dd_neg;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial;
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = {r_ff[31:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = qneg_ff ? (32'd0 - q_ff) : q_ff;
   assign div_rsp.rem  = rneg_ff ? (32'd0 - r_ff[31:0]) : r_ff[31:0];

endmodule

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: sequencer around one shared divider and one multiplier.
// Run time is dominated by Euclid gcd steps, each a pass through the bit-serial
// divider; up to four normalizations per item.
// Throughput: one item at a time; busy stays high from accept until the rsp_valid beat.
// The receiver cannot stall: the result is shown on rsp_ for one cycle.
// Reset: synchronous, returns the sequencer to idle with busy low.
module rational_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   state_type   state_ff, state_in;
   nsel_type    nsel_ff, nsel_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [31:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [31:0] n_ff, n_in, d_ff, d_in;       // fraction being normalized
   logic [31:0] ga_ff, ga_in, gb_ff, gb_in;   // gcd operands
   logic        neg_ff, neg_in;
   logic        gcd_only_ff, gcd_only_in;    // gcd for lcm, not normalization
   logic [31:0] t_ff, t_in, u_ff, u_in;
   logic [63:0] p_ff, p_in;
   logic [1:0]  ord_ff, ord_in;
   logic        err_ff, err_in;
   logic        rv_ff, rv_in;
   rsp_type     rsp_ff, rsp_in;
   div_req_type dreq;
   div_rsp_type drsp;
   logic signed [32:0] mx, my;
   logic signed [63:0] mprod;

   rau_divider u_div (.clock(clock), .reset(reset), .div_req(dreq), .div_rsp(drsp));

   assign mprod = 64'(mx) * 64'(my);

   always_comb begin
      state_in = state_ff; nsel_in = nsel_ff; cmd_in = cmd_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      n_in = n_ff; d_in = d_ff; ga_in = ga_ff; gb_in = gb_ff; neg_in = neg_ff;
      gcd_only_in = gcd_only_ff; t_in = t_ff; u_in = u_ff; p_in = p_ff;
      ord_in = ord_ff; err_in = err_ff; rv_in = 1'b0; rsp_in = rsp_ff;
      dreq = '0; mx = '0; my = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = req_data.cmd;
               an_in = req_data.a_num; ad_in = req_data.a_den;
               bn_in = req_data.b_num; bd_in = req_data.b_den;
               n_in = req_data.a_num; d_in = req_data.a_den;
               nsel_in = NS_A; err_in = 1'b0; ord_in = ORD_LT;
               gcd_only_in = 1'b0;
               state_in = ST_NORM_START;
            end
         end
         ST_NORM_START: begin
            if (d_ff == 32'd0) begin
               err_in = 1'b1;
               state_in = ST_DONE;
            end else if (n_ff == 32'd0) begin
               d_in = 32'd1;
               state_in = ST_NORM_DONE;
            end else begin
               neg_in = n_ff[31] ^ d_ff[31];
               ga_in = n_ff[31] ? (32'd0 - n_ff) : n_ff;
               gb_in = d_ff[31] ? (32'd0 - d_ff) : d_ff;
               n_in = n_ff[31] ? (32'd0 - n_ff) : n_ff;
               d_in = d_ff[31] ? (32'd0 - d_ff) : d_ff;
               state_in = ST_GCD_DIV;
            end
         end
         ST_GCD_DIV: begin
            if (gb_ff == 32'd0) begin
               state_in = gcd_only_ff ? ST_ADD_L : ST_NDIV;
            end else begin
               dreq = '{start: 1'b1, is_signed: 1'b0, dividend: ga_ff, divisor: gb_ff};
               state_in = ST_GCD_WAIT;
            end
         end
         ST_GCD_WAIT: begin
            if (drsp.done) begin
               ga_in = gb_ff;
               gb_in = drsp.rem;
               state_in = ST_GCD_DIV;
            end
         end
         ST_NDIV: begin
            dreq = '{start: 1'b1, is_signed: 1'b0, dividend: n_ff, divisor: ga_ff};
            state_in = ST_NDIV_WAIT;
         end
         ST_NDIV_WAIT: begin
            if (drsp.done) begin
               n_in = drsp.quot;
               state_in = ST_DDIV;
            end
         end
         ST_DDIV: begin
            dreq = '{start: 1'b1, is_signed: 1'b0, dividend: d_ff, divisor: ga_ff};
            state_in = ST_DDIV_WAIT;
         end
         ST_DDIV_WAIT: begin
            if (drsp.done) begin
               if (drsp.quot[31]) begin
                  err_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  d_in = drsp.quot;
                  n_in = neg_ff ? (32'd0 - n_ff) : n_ff;
                  state_in = ST_NORM_DONE;
               end
            end
         end
         ST_NORM_DONE: begin
            unique case (nsel_ff)
               NS_A: begin
                  an_in = n_ff; ad_in = d_ff;
                  n_in = bn_ff; d_in = bd_ff;
                  nsel_in = NS_B;
                  state_in = ST_NORM_START;
               end
               NS_B: begin
                  bn_in = n_ff; bd_in = d_ff;
                  state_in = ST_DISPATCH;
               end
               NS_RECIP: begin
                  bn_in = n_ff; bd_in = d_ff;
                  state_in = ST_MUL;
               end
               default: begin
                  rsp_in.res_num = n_ff;
                  rsp_in.res_den = d_ff[30:0];
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DISPATCH: begin
            nsel_in = NS_RESULT;
            case (cmd_ff)
               CMD_ADD, CMD_SUB: begin
                  if (cmd_ff == CMD_SUB) bn_in = 32'd0 - bn_ff;
                  if (ad_ff == bd_ff) begin
                     n_in = an_ff + ((cmd_ff == CMD_SUB) ? (32'd0 - bn_ff) : bn_ff);
                     d_in = ad_ff;
                     state_in = ST_NORM_START;
                  end else begin
                     state_in = ST_ADD_PROD;
                  end
               end
               CMD_MUL: state_in = ST_MUL;
               CMD_DIV: begin
                  if (bn_ff == 32'd0) begin
                     err_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     n_in = bd_ff; d_in = bn_ff;
                     nsel_in = NS_RECIP;
                     state_in = ST_NORM_START;
                  end
               end
               CMD_REM: begin
                  if (ad_ff != 32'd1 || bd_ff != 32'd1 || bn_ff == 32'd0) begin
                     err_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_REM;
                  end
               end
               CMD_CMP: state_in = ST_CMP1;
               default: begin
                  err_in = 1'b1;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_ADD_PROD: begin
            mx = {1'b0, ad_ff}; my = {1'b0, bd_ff};
            t_in = mprod[31:0];
            if (mprod[31:0] == 32'd0) begin
               err_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               ga_in = ad_ff; gb_in = bd_ff;
               gcd_only_in = 1'b1;
               state_in = ST_GCD_DIV;
            end
         end
         ST_ADD_L: begin
            // gcd is nonzero and below 2^31, so signed division matches the model
            gcd_only_in = 1'b0;
            dreq = '{start: 1'b1, is_signed: 1'b1, dividend: t_ff, divisor: ga_ff};
            state_in = ST_ADD_L_WAIT;
         end
         ST_ADD_L_WAIT: begin
            if (drsp.done) begin
               if (drsp.quot == 32'd0) begin
                  err_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  t_in = drsp.quot;
                  state_in = ST_ADD_LS;
               end
            end
         end
         ST_ADD_LS: begin
            dreq = '{start: 1'b1, is_signed: 1'b1, dividend: t_ff, divisor: ad_ff};
            state_in = ST_ADD_LS_WAIT;
         end
         ST_ADD_LS_WAIT: begin
            if (drsp.done) begin
               u_in = drsp.quot;
               state_in = ST_ADD_RS;
            end
         end
         ST_ADD_RS: begin
            dreq = '{start: 1'b1, is_signed: 1'b1, dividend: t_ff, divisor: bd_ff};
            state_in = ST_ADD_RS_WAIT;
         end
         ST_ADD_RS_WAIT: begin
            if (drsp.done) begin
               ga_in = drsp.quot;
               state_in = ST_ADD_M1;
            end
         end
         ST_ADD_M1: begin
            mx = {1'b0, an_ff}; my = {1'b0, u_ff};
            p_in = mprod;
            state_in = ST_ADD_M2;
         end
         ST_ADD_M2: begin
            mx = {1'b0, bn_ff}; my = {1'b0, ga_ff};
            n_in = p_ff[31:0] + mprod[31:0];
            d_in = t_ff;
            state_in = ST_NORM_START;
         end
         ST_MUL: begin
            mx = {1'b0, an_ff}; my = {1'b0, bn_ff};
            p_in = mprod;
            // denominator product is formed next, in the shared CMP3 step
            state_in = ST_CMP3;
            nsel_in = NS_RESULT;
         end
         ST_CMP3: begin
            if (cmd_ff == CMD_CMP) begin
               mx = {bn_ff[31], bn_ff}; my = {1'b0, ad_ff};
               ord_in = ($signed(p_ff) < mprod) ? ORD_LT :
                        (($signed(p_ff) == mprod) ? ORD_EQ : ORD_GT);
               state_in = ST_DONE;
            end else begin
               mx = {1'b0, ad_ff}; my = {1'b0, bd_ff};
               n_in = p_ff[31:0];
               d_in = mprod[31:0];
               state_in = ST_NORM_START;
            end
         end
         ST_REM: begin
            dreq = '{start: 1'b1, is_signed: 1'b1, dividend: an_ff, divisor: bn_ff};
            state_in = ST_REM_WAIT;
         end
         ST_REM_WAIT: begin
            if (drsp.done) begin
               rsp_in.res_num = drsp.rem;
               rsp_in.res_den = 31'd1;
               state_in = ST_DONE;
            end
         end
         ST_CMP1: begin
            mx = {an_ff[31], an_ff}; my = {1'b0, bd_ff};
            p_in = mprod;
            state_in = ST_CMP2;
         end
         ST_CMP2: begin
            state_in = ST_CMP3;
         end
         ST_DONE: begin
            rv_in = 1'b1;
            rsp_in.error = err_ff;
            rsp_in.order = err_ff ? ORD_LT : ord_ff;
            if (err_ff || cmd_ff == CMD_CMP) begin
               rsp_in.res_num = '0;
               rsp_in.res_den = '0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_IDLE) begin
         rsp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      n_ff <= n_in; d_ff <= d_in; ga_ff <= ga_in; gb_ff <= gb_in; neg_ff <= neg_in;
      t_ff <= t_in; u_ff <= u_in; p_ff <= p_in; ord_ff <= ord_in; err_ff <= err_in;
      rsp_ff <= rsp_in; nsel_ff <= nsel_in; gcd_only_ff <= gcd_only_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 1ps

module testbench;
   import rau_pkg::*;

   localparam int MAX_CYCLES = 50000000;
   localparam logic [2:0] CMD_BAD6 = 3'd6;
   localparam logic [2:0] CMD_BAD7 = 3'd7;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type expected_rsps[$];
   int      error_count;
   int      cycle_count;
   int      idle_pct;

   rational_arithmetic_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- fraction predictor ----------------
   function automatic logic [31:0] magnitude(logic [31:0] x);
      return x[31] ? (32'd0 - x) : x;
   endfunction

   function automatic logic [31:0] euclid(logic [31:0] a, logic [31:0] b);
      logic [31:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic bit reduce(inout logic [31:0] n, inout logic [31:0] d);
      logic [31:0] mn, md, g;
      bit neg;
      if (d == 0) return 0;
      if (n == 0) begin
         d = 32'd1;
         return 1;
      end
      neg = n[31] ^ d[31];
      mn = magnitude(n);
      md = magnitude(d);
      g = euclid(mn, md);
      mn = mn / g;
      md = md / g;
      if (md[31]) return 0;
      n = neg ? (32'd0 - mn) : mn;
      d = md;
      return 1;
   endfunction

   function automatic bit frac_add(logic [31:0] an, logic [31:0] ad, logic [31:0] bn,
                                   logic [31:0] bd, output logic [31:0] rn,
                                   output logic [31:0] rd);
      logic [31:0] prod, l, ls, rs;
      if (ad == bd) begin
         rn = an + bn;
         rd = ad;
      end else begin
         prod = ad * bd;
         if (prod == 0) return 0;
         l = 32'(longint'($signed(prod)) / longint'({32'd0, euclid(ad, bd)}));
         if (l == 0) return 0;
         ls = 32'(longint'($signed(l)) / longint'({32'd0, ad}));
         rs = 32'(longint'($signed(l)) / longint'({32'd0, bd}));
         rn = an * ls + bn * rs;
         rd = l;
      end
      return reduce(rn, rd);
   endfunction

   function automatic rsp_type predict_fraction(req_type r);
      logic [31:0] an, ad, bn, bd, rn, rd, cn, cd;
      logic [1:0] ord;
      longint lhs, rhs;
      bit ok;
      rsp_type o;
      an = r.a_num; ad = r.a_den; bn = r.b_num; bd = r.b_den;
      rn = 0; rd = 0; ord = ORD_LT;
      ok = reduce(an, ad);
      if (ok) ok = reduce(bn, bd);
      if (ok) begin
         case (r.cmd)
            CMD_ADD: ok = frac_add(an, ad, bn, bd, rn, rd);
            CMD_SUB: ok = frac_add(an, ad, 32'd0 - bn, bd, rn, rd);
            CMD_MUL: begin
               rn = an * bn;
               rd = ad * bd;
               ok = reduce(rn, rd);
            end
            CMD_DIV: begin
               cn = bd; cd = bn;
               ok = (bn != 0);
               if (ok) ok = reduce(cn, cd);
               if (ok) begin
                  rn = an * cn;
                  rd = ad * cd;
                  ok = reduce(rn, rd);
               end
            end
            CMD_REM: begin
               if (ad != 1 || bd != 1 || bn == 0) ok = 0;
               else begin
                  rn = 32'(longint'($signed(an)) % longint'($signed(bn)));
                  rd = 1;
               end
            end
            CMD_CMP: begin
               lhs = longint'($signed(an)) * longint'({32'd0, bd});
               rhs = longint'($signed(bn)) * longint'({32'd0, ad});
               ord = (lhs < rhs) ? ORD_LT : ((lhs == rhs) ? ORD_EQ : ORD_GT);
            end
            default: ok = 0;
         endcase
      end
      if (!ok) begin
         rn = 0; rd = 0; ord = ORD_LT;
      end
      o.res_num = rn;
      o.res_den = rd[30:0];
      o.order = ord;
      o.error = !ok;
      return o;
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count <= error_count + 1;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.res_num !== want.res_num || rsp_data.res_den !== want.res_den ||
                rsp_data.order !== want.order || rsp_data.error !== want.error) begin
               $display("%0t: mismatch expected num=%0d den=%0d ord=%0d err=%0b",
                        $time, want.res_num, want.res_den, want.order, want.error);
               $display("%0t:          actual num=%0d den=%0d ord=%0d err=%0b",
                        $time, rsp_data.res_num, rsp_data.res_den, rsp_data.order,
                        rsp_data.error);
               error_count <= error_count + 1;
            end
         end
      end
   end

   always @(posedge clock)
      if (cycle_count >= MAX_CYCLES) begin
         $display("testbench failed");
         $finish;
      end

   // ---------------- stimulus ----------------
   // called at a falling edge; start is high for exactly the accepting cycle
   task automatic send_beat(req_type r);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      while (busy) @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      expected_rsps.push_back(predict_fraction(r));
      @(negedge clock);
      start <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value(bit den);
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return den ? 32'd0 : 32'hffff_ffff;
         3: return 32'($urandom);
         4: return 32'($urandom_range(65535)) << $urandom_range(16);
         5: return -32'($urandom_range(1, 12));
         default: return den ? 32'($urandom_range(1, 60)) : 32'($urandom_range(0, 120)) - 60;
      endcase
   endfunction

   function automatic req_type random_req();
      req_type r;
      r.cmd = ($urandom_range(49) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
      r.a_num = pick_value(0);
      r.b_num = pick_value(0);
      r.a_den = pick_value(1);
      r.b_den = pick_value(1);
      // keep remainder mostly on integers
      if (r.cmd == CMD_REM && $urandom_range(3) != 0) begin
         r.a_den = 1;
         r.b_den = ($urandom_range(3) == 0) ? -1 : 1;
      end
      return r;
   endfunction

   function automatic req_type make_req(logic [2:0] c, logic [31:0] an, logic [31:0] ad,
                                        logic [31:0] bn, logic [31:0] bd);
      req_type r;
      r.cmd = c; r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
      return r;
   endfunction

   task automatic test_directed();
      idle_pct = 0;
      send_beat(make_req(CMD_ADD, 1, 2, 1, 3));
      send_beat(make_req(CMD_SUB, 1, 2, 1, 2));
      send_beat(make_req(CMD_MUL, -6, 4, 2, -3));
      send_beat(make_req(CMD_DIV, 3, 4, -9, 8));
      send_beat(make_req(CMD_REM, -7, 1, 2, 1));
      send_beat(make_req(CMD_CMP, 1, 3, 2, 6));
      send_beat(make_req(CMD_CMP, -1, 3, 1, 6));
      send_beat(make_req(CMD_CMP, 5, 3, 1, 6));
      send_beat(make_req(CMD_ADD, 0, 0, 1, 1));              // zero denominator
      send_beat(make_req(CMD_MUL, 1, 65536, 1, 65536));      // product wraps to zero
      send_beat(make_req(CMD_ADD, 1, 32'h8000_0000, 1, 1));  // oversized denominator
      send_beat(make_req(CMD_DIV, 1, 1, 0, 5));              // zero divisor
      send_beat(make_req(CMD_REM, 1, 1, 0, 1));
      send_beat(make_req(CMD_REM, 1, 2, 3, 1));              // non-integer remainder
      send_beat(make_req(CMD_REM, 32'h8000_0000, 1, -1, 1));
      send_beat(make_req(CMD_BAD6, 1, 1, 1, 1));
      send_beat(make_req(CMD_BAD7, 1, 1, 1, 1));
      send_beat(make_req(CMD_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1));
      send_beat(make_req(CMD_SUB, 32'h8000_0000, -1, 1, 1));
      send_beat(make_req(CMD_ADD, 1, 46341, 1, 46349));
      send_beat(make_req(CMD_MUL, 32'h8000_0000, 3, -1, 1));
      send_beat(make_req(CMD_CMP, 32'h8000_0000, 1, 32'h7fff_ffff, 32'h7fff_ffff));
      send_beat(make_req(CMD_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 7));
   endtask

   task automatic test_random(int n, int pct);
      idle_pct = pct;
      repeat (n) send_beat(random_req());
   endtask

   task automatic test_drain_pause();
      while (expected_rsps.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      idle_pct = 0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(400, 0);
      test_drain_pause();
      test_random(400, 57);
      test_random(350, 0);
      test_random(400, 12);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

endmodule
